/* rtl/tpi_pkg.sv */
// Shared types and constants for the three-plane intersection block.
`default_nettype none
package tpi_pkg;

  localparam int FIELD_WIDTH = 16;
  localparam int COORD_WIDTH = 32;
  localparam int COEF_WIDTH  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] plane1_a;
    logic signed [FIELD_WIDTH-1:0] plane1_b;
    logic signed [FIELD_WIDTH-1:0] plane1_c;
    logic signed [FIELD_WIDTH-1:0] plane1_d;
    logic signed [FIELD_WIDTH-1:0] plane2_a;
    logic signed [FIELD_WIDTH-1:0] plane2_b;
    logic signed [FIELD_WIDTH-1:0] plane2_c;
    logic signed [FIELD_WIDTH-1:0] plane2_d;
    logic signed [FIELD_WIDTH-1:0] plane3_a;
    logic signed [FIELD_WIDTH-1:0] plane3_b;
    logic signed [FIELD_WIDTH-1:0] plane3_c;
    logic signed [FIELD_WIDTH-1:0] plane3_d;
  } tpi_req_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          solvable;
    logic                          saturated;
  } tpi_res_t;

endpackage
`default_nettype wire

/* rtl/tpi_front.sv */
// Front pipeline: coefficient extraction, 2x2 minors and the four 3x3 determinants.
`default_nettype none
module tpi_front #(
  parameter int COEF_WIDTH = tpi_pkg::COEF_WIDTH,
  parameter int DW         = 3 * COEF_WIDTH + 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire tpi_pkg::tpi_req_t req_i,
  output logic                  busy_o,
  input  wire logic             full_i,
  output logic                  valid_o,
  output logic signed [DW-1:0]  dm_o,
  output logic signed [DW-1:0]  dx_o,
  output logic signed [DW-1:0]  dy_o,
  output logic signed [DW-1:0]  dz_o
);

  localparam int C  = COEF_WIDTH;
  localparam int EW = C + 1;
  localparam int MW = 2 * C + 1;
  localparam int RW = (C > tpi_pkg::FIELD_WIDTH) ? C : tpi_pkg::FIELD_WIDTH;

  localparam int MP [7]  = '{1, 0, 0, 3, 3, 0, 1};
  localparam int MQ [7]  = '{2, 2, 1, 2, 1, 3, 3};
  localparam int PR [12] = '{0, 1, 2, 3, 1, 2, 0, 3, 2, 0, 1, 3};
  localparam int PM [12] = '{0, 1, 2, 0, 3, 4, 3, 1, 5, 6, 5, 2};

  logic [tpi_pkg::FIELD_WIDTH-1:0] fld [12];
  logic [RW-1:0]                   raw [12];
  logic signed [EW-1:0]            cf  [12];
  logic signed [EW-1:0]            m_d [3][4];
  logic signed [EW-1:0]            m_q [3][4];
  logic signed [2*EW-1:0]          pa  [7];
  logic signed [2*EW-1:0]          pb  [7];
  logic signed [MW-1:0]            mn_d [7];
  logic signed [MW-1:0]            mn_q [7];
  logic signed [EW-1:0]            r0_q [4];
  logic signed [EW+MW-1:0]         pr  [12];
  logic signed [DW-1:0]            p_q [12];
  logic signed [DW-1:0]            det_q [4];
  logic [3:0]                      v_q;
  logic                            adv;

  assign adv    = !(v_q[3] && full_i);
  assign busy_o = !adv;

  always_comb begin
    fld[0]  = req_i.plane1_a;  fld[1]  = req_i.plane1_b;
    fld[2]  = req_i.plane1_c;  fld[3]  = req_i.plane1_d;
    fld[4]  = req_i.plane2_a;  fld[5]  = req_i.plane2_b;
    fld[6]  = req_i.plane2_c;  fld[7]  = req_i.plane2_d;
    fld[8]  = req_i.plane3_a;  fld[9]  = req_i.plane3_b;
    fld[10] = req_i.plane3_c;  fld[11] = req_i.plane3_d;
    for (int i = 0; i < 12; i++) begin
      raw[i] = RW'(fld[i]);
      cf[i]  = EW'($signed(raw[i][C-1:0]));
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m_d[r][c] = cf[4*r+c];
      end
      m_d[r][3] = -cf[4*r+3];
    end
  end

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      pa[i]   = m_q[1][MP[i]] * m_q[2][MQ[i]];
      pb[i]   = m_q[1][MQ[i]] * m_q[2][MP[i]];
      mn_d[i] = MW'(pa[i] - pb[i]);
    end
    for (int i = 0; i < 12; i++) begin
      pr[i] = r0_q[PR[i]] * mn_q[PM[i]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q  <= m_d;
      mn_q <= mn_d;
      r0_q <= m_q[0];
      for (int i = 0; i < 12; i++) begin
        p_q[i] <= DW'(pr[i]);
      end
      for (int k = 0; k < 4; k++) begin
        det_q[k] <= p_q[3*k] - p_q[3*k+1] + p_q[3*k+2];
      end
    end
  end

  assign valid_o = v_q[3];
  assign dm_o    = det_q[0];
  assign dx_o    = det_q[1];
  assign dy_o    = det_q[2];
  assign dz_o    = det_q[3];

endmodule
`default_nettype wire

/* rtl/tpi_fifo.sv */
// Short request queue between the determinant front and the divider back.
`default_nettype none
module tpi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tpi_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/tpi_back.sv */
// Back pipeline: restoring long division of each determinant ratio with saturation.
`default_nettype none
module tpi_back #(
  parameter int COEF_WIDTH = tpi_pkg::COEF_WIDTH,
  parameter int FRAC_BITS  = tpi_pkg::FRAC_BITS,
  parameter int DW         = 3 * COEF_WIDTH + 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic signed [DW-1:0] dm_i,
  input  wire logic signed [DW-1:0] dx_i,
  input  wire logic signed [DW-1:0] dy_i,
  input  wire logic signed [DW-1:0] dz_i,
  output logic                    done_o,
  output tpi_pkg::tpi_res_t       res_o
);

  localparam int QW    = tpi_pkg::COORD_WIDTH;
  localparam int STEPS = QW;
  localparam int NW    = DW + FRAC_BITS + QW;

  logic [DW-1:0] r_q   [STEPS+1][3];
  logic [QW-1:0] lo_q  [STEPS+1][3];
  logic [QW-1:0] q_q   [STEPS+1][3];
  logic [2:0]    neg_q [STEPS+1];
  logic [2:0]    ovf_q [STEPS+1];
  logic [DW-1:0] den_q [STEPS+1];
  logic          sol_q [STEPS+1];
  logic [STEPS:0] v_q;

  logic signed [DW-1:0] num  [3];
  logic [DW-1:0]        nmag [3];
  logic [NW-1:0]        nsh  [3];
  logic [NW-1:0]        hi   [3];
  logic [DW-1:0]        dmag;
  logic                 nz;

  always_comb begin
    num[0] = dx_i;
    num[1] = dy_i;
    num[2] = dz_i;
    nz     = (dm_i != '0);
    dmag   = !nz ? DW'(1) : (dm_i[DW-1] ? (~dm_i + 1'b1) : dm_i);
    for (int k = 0; k < 3; k++) begin
      nmag[k] = num[k][DW-1] ? (~num[k] + 1'b1) : num[k];
      nsh[k]  = NW'(nmag[k]) << FRAC_BITS;
      hi[k]   = nsh[k] >> QW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[STEPS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    den_q[0] <= dmag;
    sol_q[0] <= nz;
    for (int k = 0; k < 3; k++) begin
      r_q[0][k]    <= hi[k][DW-1:0];
      lo_q[0][k]   <= nsh[k][QW-1:0];
      q_q[0][k]    <= '0;
      neg_q[0][k]  <= num[k][DW-1] ^ dm_i[DW-1];
      ovf_q[0][k]  <= (hi[k] >= NW'(dmag));
    end
  end

  for (genvar j = 1; j <= STEPS; j++) begin : g_step
    logic [DW:0]   trial [3];
    logic [DW-1:0] rn    [3];
    logic [2:0]    ge;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        trial[k] = {r_q[j-1][k], lo_q[j-1][k][QW-1]};
        ge[k]    = (trial[k] >= {1'b0, den_q[j-1]});
        rn[k]    = ge[k] ? DW'(trial[k] - {1'b0, den_q[j-1]}) : trial[k][DW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[j] <= den_q[j-1];
      sol_q[j] <= sol_q[j-1];
      neg_q[j] <= neg_q[j-1];
      ovf_q[j] <= ovf_q[j-1];
      for (int k = 0; k < 3; k++) begin
        r_q[j][k]  <= rn[k];
        lo_q[j][k] <= {lo_q[j-1][k][QW-2:0], 1'b0};
        q_q[j][k]  <= {q_q[j-1][k][QW-2:0], ge[k]};
      end
    end
  end

  logic [QW-1:0] lim [3];
  logic [QW-1:0] val [3];
  logic [QW-1:0] co  [3];
  logic [2:0]    sat;
  tpi_pkg::tpi_res_t res_d, res_q;
  logic          done_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lim[k] = neg_q[STEPS][k] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      sat[k] = ovf_q[STEPS][k] || (q_q[STEPS][k] > lim[k]);
      val[k] = sat[k] ? lim[k] : q_q[STEPS][k];
      co[k]  = sol_q[STEPS] ? (neg_q[STEPS][k] ? (~val[k] + 1'b1) : val[k]) : '0;
    end
    res_d.point_x   = $signed(co[0]);
    res_d.point_y   = $signed(co[1]);
    res_d.point_z   = $signed(co[2]);
    res_d.solvable  = sol_q[STEPS];
    res_d.saturated = sol_q[STEPS] && (sat != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

/* rtl/three_plane_intersection.sv */
// Top level of the three-plane intersection block.
// Usage:
//   Request channel: drive req_i and raise start; the request is taken at a
//   rising edge where start is high and busy is low. A new request may be
//   taken in every cycle.
//   Result channel: done_o is high for one cycle with res_o holding the
//   point, the solvable flag and the saturated flag. The receiver cannot
//   stall; results appear in request order.
//   Path: from the accepting edge to the done strobe a request passes four
//   stages of determinant arithmetic, the queue, one operand stage, 32
//   one-bit steps of the divider pipeline and the result register.
//   Throughput: one request per cycle, set by the fully pipelined divider
//   that retires one quotient bit per stage for all three coordinates.
//   busy rises only when the queue is full, which the always-draining back
//   end never lets happen in operation.
//   Reset: clears all valid bits and queue pointers; no state survives
//   between requests.
`default_nettype none
module three_plane_intersection #(
  parameter int COEF_WIDTH = tpi_pkg::COEF_WIDTH,
  parameter int FRAC_BITS  = tpi_pkg::FRAC_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire tpi_pkg::tpi_req_t req_i,
  output logic                   done_o,
  output tpi_pkg::tpi_res_t      res_o
);

  localparam int DW = 3 * COEF_WIDTH + 1;

  logic                 f_valid, q_full, q_empty, push;
  logic signed [DW-1:0] f_dm, f_dx, f_dy, f_dz;
  logic [4*DW-1:0]      q_out;

  tpi_front #(
    .COEF_WIDTH(COEF_WIDTH),
    .DW        (DW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .req_i  (req_i),
    .busy_o (busy),
    .full_i (q_full),
    .valid_o(f_valid),
    .dm_o   (f_dm),
    .dx_o   (f_dx),
    .dy_o   (f_dy),
    .dz_o   (f_dz)
  );

  assign push = f_valid && !q_full;

  tpi_fifo #(
    .WIDTH(4 * DW),
    .DEPTH(tpi_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({f_dm, f_dx, f_dy, f_dz}),
    .full_o (q_full),
    .pop_i  (!q_empty),
    .empty_o(q_empty),
    .data_o (q_out)
  );

  tpi_back #(
    .COEF_WIDTH(COEF_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .DW        (DW)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(!q_empty),
    .dm_i   ($signed(q_out[4*DW-1:3*DW])),
    .dx_i   ($signed(q_out[3*DW-1:2*DW])),
    .dy_i   ($signed(q_out[2*DW-1:DW])),
    .dz_i   ($signed(q_out[DW-1:0])),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule
`default_nettype wire
